// ===== sv/vlrb_pkg.sv =====
// Package: types, codes and defaults for the variable-length record buffer.
`default_nettype none
package vlrb_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned MAX_RECORDS_DEF = 64;

  localparam int unsigned CAP_BYTES_W = 13;
  localparam int unsigned CAP_ITEMS_W = 7;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CAP_BYTES_W-1:0] CAP_BYTES_RST = 13'd4096;
  localparam logic [CAP_ITEMS_W-1:0] CAP_ITEMS_RST = 7'd64;

  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LENGTH_W = 13;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ADDR_W   = 12;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_GET   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_COMMIT  = 3'd0,
    ST_REJECT  = 3'd1,
    ST_DESC    = 3'd2,
    ST_BAD_IDX = 3'd3,
    ST_BYTE    = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef enum logic {
    CFG_CAP_BYTES = 1'b0,
    CFG_CAP_ITEMS = 1'b1
  } cfg_e;

  typedef struct packed {
    status_e              status;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
    logic                 is_get;
    logic                 is_read;
    logic                 hit;
  } vlrb_s1_t;

endpackage
`default_nettype wire

// ===== sv/vlrb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module vlrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/variable_length_record_buffer_core.sv =====
// Top level: request decode, fill counters, record index and byte memories, result stage.
// Result path: a request's result is held in the stage-one register, where the memory read
// is taken, then in the output register; a push byte that is not last gives no result.
// Throughput: one request per cycle unless stage one waits on a stalled output; a push writes
// the byte memory (if last, also the index memory), a get or read reads index or byte memory.
// Reset: counters and capacity registers return to defaults at once; the memories are
// not cleared and need no clearing pass.
`default_nettype none
module variable_length_record_buffer_core
  import vlrb_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] data_byte, [13:8] item_index, [25:14] byte_addr, [31:26] zero
  input  wire logic [31:0]           s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [5:0] record_index, [17:6] record_offset, [30:18] record_length,
  // [38:31] read_data, [45:39] record_count, [47:46] zero
  output logic [47:0]                m_axis_tdata,
  // [2:0] status
  output logic [2:0]                 m_axis_tuser
);

  localparam int unsigned AW  = $clog2(STORE_BYTES);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned XW  = (CW > CAP_BYTES_W) ? CW : CAP_BYTES_W;
  localparam int unsigned RW  = $clog2(MAX_RECORDS);
  localparam int unsigned RCW = RW + 1;
  localparam int unsigned YW  = (RCW > CAP_ITEMS_W) ? RCW : CAP_ITEMS_W;

  logic [CAP_BYTES_W-1:0] cap_bytes_q;
  logic [CAP_ITEMS_W-1:0] cap_items_q;

  logic [CW-1:0]  used_q, used_d, pending_q, pending_d;
  logic           ovf_q, ovf_d;
  logic [RCW-1:0] recs_q, recs_d;

  logic      s1_valid_q, s1_valid_d, s1_load;
  vlrb_s1_t  s1_q, s1_d;

  logic                m_valid_q, m_valid_d;
  status_e             m_status_q;
  logic [INDEX_W-1:0]  m_index_q;
  logic [OFFSET_W-1:0] m_offset_q;
  logic [LENGTH_W-1:0] m_length_q;
  logic [DATA_W-1:0]   m_data_q;
  logic [COUNT_W-1:0]  m_count_q;

  req_e              req;
  logic [DATA_W-1:0] in_data;
  logic [INDEX_W-1:0] in_item;
  logic [ADDR_W-1:0] in_addr;
  logic [XW-1:0]     addr_x;
  logic [YW-1:0]     item_x;
  logic [CW-1:0]     pos, pos_inc;
  logic              in_fire, out_free, s1_adv;
  logic              room, fits, items_ok, commit;

  logic              byte_we, byte_re, tbl_we, tbl_re;
  logic [DATA_W-1:0] byte_rdata;
  logic [2*CW-1:0]   tbl_wdata, tbl_rdata;
  logic [CW-1:0]     tbl_end, tbl_len;

  assign req     = req_e'(s_axis_tuser);
  assign in_data = s_axis_tdata[7:0];
  assign in_item = s_axis_tdata[13:8];
  assign in_addr = s_axis_tdata[25:14];
  assign addr_x  = XW'(in_addr);
  assign item_x  = YW'(in_item);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign pos      = used_q + pending_q;
  assign pos_inc  = pos + CW'(1);
  assign room     = (XW'(pos) < XW'(cap_bytes_q)) && (XW'(pos) < XW'(STORE_BYTES));
  assign fits     = !ovf_q && room;
  assign items_ok = (YW'(recs_q) < YW'(cap_items_q)) && (YW'(recs_q) < YW'(MAX_RECORDS));
  assign commit   = fits && items_ok;

  assign byte_we   = in_fire && (req == REQ_PUSH) && fits;
  assign tbl_we    = in_fire && (req == REQ_PUSH) && s_axis_tlast && commit;
  assign tbl_wdata = {pos_inc, pending_q + CW'(1)};
  assign byte_re   = in_fire && (req == REQ_READ);
  assign tbl_re    = in_fire && (req == REQ_GET);

  always_comb begin
    used_d    = used_q;
    pending_d = pending_q;
    ovf_d     = ovf_q;
    recs_d    = recs_q;
    s1_load   = 1'b0;
    s1_d      = '{status: ST_CLEARED, index: '0, count: COUNT_W'(recs_q),
                  is_get: 1'b0, is_read: 1'b0, hit: 1'b0};
    if (in_fire) begin
      unique case (req)
        REQ_PUSH: begin
          if (fits) begin
            pending_d = pending_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            s1_load   = 1'b1;
            pending_d = '0;
            ovf_d     = 1'b0;
            if (commit) begin
              used_d      = pos_inc;
              recs_d      = recs_q + RCW'(1);
              s1_d.status = ST_COMMIT;
              s1_d.index  = INDEX_W'(recs_q);
              s1_d.count  = COUNT_W'(recs_q + RCW'(1));
            end else begin
              s1_d.status = ST_REJECT;
            end
          end
        end
        REQ_GET: begin
          s1_load     = 1'b1;
          s1_d.is_get = 1'b1;
          s1_d.hit    = (item_x < YW'(recs_q)) && (item_x < YW'(MAX_RECORDS));
          s1_d.status = s1_d.hit ? ST_DESC : ST_BAD_IDX;
        end
        REQ_READ: begin
          s1_load      = 1'b1;
          s1_d.is_read = 1'b1;
          s1_d.hit     = (addr_x < XW'(used_q)) && (addr_x < XW'(STORE_BYTES));
          s1_d.status  = ST_BYTE;
        end
        REQ_CLEAR: begin
          s1_load    = 1'b1;
          used_d     = '0;
          pending_d  = '0;
          ovf_d      = 1'b0;
          recs_d     = '0;
          s1_d.count = '0;
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end
    m_valid_d = m_valid_q;
    if (s1_adv) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_bytes_q <= CAP_BYTES_RST;
      cap_items_q <= CAP_ITEMS_RST;
      used_q      <= '0;
      pending_q   <= '0;
      ovf_q       <= 1'b0;
      recs_q      <= '0;
      s1_valid_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_CAP_BYTES: cap_bytes_q <= cfg_data_i;
          CFG_CAP_ITEMS: cap_items_q <= cfg_data_i[CAP_ITEMS_W-1:0];
        endcase
      end
      used_q     <= used_d;
      pending_q  <= pending_d;
      ovf_q      <= ovf_d;
      recs_q     <= recs_d;
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  assign tbl_end = tbl_rdata[2*CW-1:CW];
  assign tbl_len = tbl_rdata[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      m_status_q <= s1_q.status;
      m_index_q  <= s1_q.index;
      m_count_q  <= s1_q.count;
      m_offset_q <= (s1_q.is_get && s1_q.hit) ? OFFSET_W'(tbl_end - tbl_len) : '0;
      m_length_q <= (s1_q.is_get && s1_q.hit) ? LENGTH_W'(tbl_len) : '0;
      m_data_q   <= (s1_q.is_read && s1_q.hit) ? byte_rdata : '0;
    end
  end

  vlrb_ram #(
    .Width (DATA_W),
    .Depth (STORE_BYTES)
  ) u_byte_mem (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (pos[AW-1:0]),
    .wdata_i (in_data),
    .re_i    (byte_re),
    .raddr_i (addr_x[AW-1:0]),
    .rdata_o (byte_rdata)
  );

  vlrb_ram #(
    .Width (2*CW),
    .Depth (MAX_RECORDS)
  ) u_index_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (recs_q[RW-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (item_x[RW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {2'b00, m_count_q, m_data_q, m_length_q, m_offset_q, m_index_q};

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(STORE_BYTES))
    else $error("committed area exceeds store");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CW+1)'(used_q) + (CW+1)'(pending_q)) <= (CW+1)'(STORE_BYTES))
    else $error("pending record runs past store");

  a_recs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recs_q <= RCW'(MAX_RECORDS))
    else $error("record count exceeds index table");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (req == REQ_CLEAR) |=> used_q == '0 && recs_q == '0 && pending_q == '0)
    else $error("clear left stale counters");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q)
    else $error("pending result lost while output stalled");

endmodule
`default_nettype wire
